// ===== rtl/cda_pkg.sv =====
// shared types, constants and calendar functions for the date advance block
package cda_pkg;

  // field widths
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned OffW   = 9;
  localparam int unsigned TotalW = 10;

  // offset register value after reset
  localparam logic [OffW-1:0] OFFSET_RESET = 9'd60;

  // reciprocal of 100 for the year quotient: q = (y * RECIP_100) >> RECIP_SHIFT
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned RecipW      = 13;
  localparam logic [RecipW-1:0] RECIP_100 = 13'd5243;
  localparam int unsigned ProdW       = YearW + RecipW;
  localparam int unsigned QuotW       = ProdW - RECIP_SHIFT;

  // month numbering and year lengths
  localparam logic [MonW-1:0]   MON_JAN  = 4'd1;
  localparam logic [MonW-1:0]   MON_FEB  = 4'd2;
  localparam logic [MonW-1:0]   MON_DEC  = 4'd12;
  localparam logic [TotalW-1:0] YEAR_LEN = 10'd365;
  localparam logic [TotalW-1:0] LEAP_LEN = 10'd366;

  // input beat
  typedef struct packed {
    logic [DayW-1:0]  start_day;
    logic [MonW-1:0]  start_month;
    logic [YearW-1:0] start_year;
  } in_t;

  // result beat
  typedef struct packed {
    logic             date_valid;
    logic             in_year;
    logic [DayW-1:0]  result_day;
    logic [MonW-1:0]  result_month;
    logic [YearW-1:0] result_year;
  } out_t;

  // one step of the month walk
  typedef struct packed {
    logic              go;
    logic [TotalW-1:0] total_nxt;
    logic [MonW-1:0]   month_nxt;
  } walk_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUOT,
    ST_LEAP,
    ST_CHECK,
    ST_WALK,
    ST_DONE
  } state_t;

  // days in month m (1..12); codes outside that range give 31
  function automatic logic [DayW-1:0] days_in(input logic [MonW-1:0] m, input logic leap);
    logic [DayW-1:0] d;
    d = 5'd31;
    case (m) inside
      MON_FEB:                   d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  // days before month m in a common year
  function automatic logic [8:0] days_before(input logic [MonW-1:0] m);
    logic [8:0] c;
    c = 9'd0;
    case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/cda_leap.sv =====
// leap-year unit: reciprocal quotient by 100, then the leap decision, one register each
module cda_leap (
  input  logic                      clk,
  input  logic                      quot_en,
  input  logic                      leap_en,
  input  logic [cda_pkg::YearW-1:0] year,
  output logic                      leap
);
  import cda_pkg::*;

  logic [ProdW-1:0] prod;
  logic [QuotW-1:0] quot_r;
  logic [YearW:0]   back;
  logic             div100;
  logic             leap_nxt;
  logic             leap_r;

  // floor(year / 100), exact over the full year range
  assign prod = ProdW'(year) * ProdW'(RECIP_100);

  always_ff @(posedge clk) begin
    if (quot_en) begin
      quot_r <= prod[ProdW-1 -: QuotW];
    end
  end

  // divisible by 4 and not by 100, or divisible by 400 (= by 100 and by 16)
  assign back     = (YearW+1)'(quot_r) * (YearW+1)'(100);
  assign div100   = (back == {1'b0, year});
  assign leap_nxt = (year[1:0] == 2'b00) && (!div100 || (year[3:0] == 4'b0000));

  always_ff @(posedge clk) begin
    if (leap_en) begin
      leap_r <= leap_nxt;
    end
  end

  assign leap = leap_r;

endmodule

// ===== rtl/cda_walk.sv =====
// month walk unit: compares the remaining days with one month and subtracts it
module cda_walk (
  input  logic                       leap,
  input  logic [cda_pkg::MonW-1:0]   month,
  input  logic [cda_pkg::TotalW-1:0] total,
  output cda_pkg::walk_t             step
);
  import cda_pkg::*;

  logic [DayW-1:0] dim;

  assign dim = days_in(month, leap);

  // step on while more days remain than this month holds, December being last
  assign step.go        = (month < MON_DEC) && (total > TotalW'(dim));
  assign step.total_nxt = total - TotalW'(dim);
  assign step.month_nxt = month + MonW'(1);

endmodule

// ===== rtl/calendar_date_add_days.sv =====
// top level: date check and day advance within one calendar year
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------
//   in_     | input     | in_valid/in_stall  | cda_pkg::in_t
//   out_    | output    | out_valid/out_stall| cda_pkg::out_t
//   cfg_    | input     | cfg_wr_en          | day_offset (9 bits)
//
// one date at a time: accept, quotient, leap, check, then one month per cycle
// in the walk unit (11 month steps at most), then the output register is loaded
// once it is free; a date that is invalid or leaves its year skips the walk.
// rst_n (synchronous) clears the sequencer and output valid and sets the offset to 60.
// the output register frees the core, so a stalled result only holds the next one in done.
module calendar_date_add_days (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  cda_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output cda_pkg::out_t               out_data,
  input  logic                        cfg_wr_en,
  input  logic [cda_pkg::OffW-1:0]    cfg_wr_data
);
  import cda_pkg::*;

  state_t            state_r, state_nxt;
  logic [OffW-1:0]   offset_r;
  logic [DayW-1:0]   day_r;
  logic [MonW-1:0]   month_r;
  logic [YearW-1:0]  year_r;
  logic [TotalW-1:0] total_r;
  logic [MonW-1:0]   mon_r;
  logic              valid_r;
  logic              iny_r;
  out_t              out_r;
  logic              out_valid_r;

  logic              leap;
  walk_t             step;
  logic              in_acc;
  logic              slot_free;
  logic              quot_en, leap_en, check_en, walk_en, load_out;

  logic [DayW-1:0]   start_dim;
  logic              date_ok;
  logic [TotalW-1:0] doy;
  logic [TotalW-1:0] ylen;

  // shared units
  cda_leap u_leap (
    .clk     (clk),
    .quot_en (quot_en),
    .leap_en (leap_en),
    .year    (year_r),
    .leap    (leap)
  );

  cda_walk u_walk (
    .leap  (leap),
    .month (mon_r),
    .total (total_r),
    .step  (step)
  );

  // date check and day of year after the offset
  assign start_dim = days_in(month_r, leap);
  assign date_ok   = (year_r != '0) && (month_r >= MON_JAN) && (month_r <= MON_DEC) &&
                     (day_r != '0) && (day_r <= start_dim);
  assign doy       = TotalW'(days_before(month_r)) +
                     TotalW'(leap && (month_r > MON_FEB)) +
                     TotalW'(day_r) + TotalW'(offset_r);
  assign ylen      = leap ? LEAP_LEN : YEAR_LEN;

  assign slot_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_QUOT;
      ST_QUOT:  state_nxt = ST_LEAP;
      ST_LEAP:  state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (date_ok && (doy <= ylen)) state_nxt = ST_WALK;
        else                          state_nxt = ST_DONE;
      end
      ST_WALK:  if (!step.go) state_nxt = ST_DONE;
      ST_DONE:  if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    quot_en  = 1'b0;
    leap_en  = 1'b0;
    check_en = 1'b0;
    walk_en  = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_QUOT:  quot_en  = 1'b1;
      ST_LEAP:  leap_en  = 1'b1;
      ST_CHECK: check_en = 1'b1;
      ST_WALK:  walk_en  = 1'b1;
      ST_DONE:  load_out = slot_free;
      default:  in_stall = 1'b1;
    endcase
  end

  assign in_acc = in_valid && !in_stall;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      offset_r    <= OFFSET_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        offset_r <= cfg_wr_data;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      day_r   <= in_data.start_day;
      month_r <= in_data.start_month;
      year_r  <= in_data.start_year;
    end
    if (check_en) begin
      valid_r <= date_ok;
      iny_r   <= 1'b0;
      total_r <= doy;
      mon_r   <= MON_JAN;
    end
    if (walk_en) begin
      if (step.go) begin
        total_r <= step.total_nxt;
        mon_r   <= step.month_nxt;
      end else begin
        iny_r <= 1'b1;
      end
    end
  end

  // output register, day, month and year zero unless the date stays in its year
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.date_valid   <= valid_r;
      out_r.in_year      <= iny_r;
      out_r.result_day   <= iny_r ? total_r[DayW-1:0] : '0;
      out_r.result_month <= iny_r ? mon_r : '0;
      out_r.result_year  <= iny_r ? year_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== test/tb_calendar_date_add_days.sv =====
// testbench for the calendar date advance block: predicted results, random traffic, stalls
`timescale 1ns / 1ps

module tb_calendar_date_add_days;
  import cda_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned DrainWait  = 30;
  localparam int unsigned HoldCycles = 250;
  localparam int unsigned HoldAfter  = 400;
  localparam int unsigned PhaseItems = 215;
  localparam int unsigned CalmItems  = 150;
  localparam int unsigned NumPhases  = 8;

  // expected-date store and calendar predictor
  class date_board;
    out_t                  expected_q[$];
    logic [OffW-1:0]       offset;
    int unsigned           errors;
    int unsigned           accepted;

    function new();
      offset   = OFFSET_RESET;
      errors   = 0;
      accepted = 0;
    endfunction

    static function bit leap_year(int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
    endfunction

    static function int unsigned month_days(int unsigned m, int unsigned y);
      case (m)
        MON_FEB:        return leap_year(y) ? 29 : 28;
        4, 6, 9, 11:    return 30;
        default:        return 31;
      endcase
    endfunction

    // day-of-year walk forward by the offset, zero fields when it leaves the year
    function out_t advance(in_t d);
      out_t        r;
      int unsigned doy;
      int unsigned ylen;
      int unsigned m;
      int unsigned y;
      r = '0;
      y = d.start_year;
      if (y == 0 || d.start_month < MON_JAN || d.start_month > MON_DEC ||
          d.start_day == 0 || d.start_day > month_days(d.start_month, y))
        return r;
      r.date_valid = 1'b1;
      doy = d.start_day;
      for (m = 1; m < d.start_month; m++)
        doy += month_days(m, y);
      doy += offset;
      ylen = leap_year(y) ? 366 : 365;
      if (doy > ylen)
        return r;
      m = 1;
      while (m < 12 && doy > month_days(m, y)) begin
        doy -= month_days(m, y);
        m++;
      end
      r.in_year      = 1'b1;
      r.result_day   = doy[DayW-1:0];
      r.result_month = m[MonW-1:0];
      r.result_year  = d.start_year;
      return r;
    endfunction

    function void note_date(in_t d);
      expected_q.push_back(advance(d));
      accepted++;
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with no date waiting: %p", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.date_valid !== want.date_valid) begin
        $error("date_valid expected %0d got %0d", want.date_valid, got.date_valid);
        errors++;
      end
      if (got.in_year !== want.in_year) begin
        $error("in_year expected %0d got %0d", want.in_year, got.in_year);
        errors++;
      end
      if (got.result_day !== want.result_day) begin
        $error("result_day expected %0d got %0d", want.result_day, got.result_day);
        errors++;
      end
      if (got.result_month !== want.result_month) begin
        $error("result_month expected %0d got %0d", want.result_month, got.result_month);
        errors++;
      end
      if (got.result_year !== want.result_year) begin
        $error("result_year expected %0d got %0d", want.result_year, got.result_year);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  in_t             in_data;
  logic            out_valid;
  logic            out_stall;
  out_t            out_data;
  logic            cfg_wr_en;
  logic [OffW-1:0] cfg_wr_data;

  date_board   sb;
  bit          calm;
  bit          held;
  int unsigned hold_left;
  int unsigned rx_left;
  int unsigned rx_mode_left;
  int unsigned rx_pct;
  int unsigned cycle_count;

  calendar_date_add_days i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // beat monitors on both channels
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_date(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // result-side stall: random bursts, one long hold, none in the calm tail
  always @(posedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (!held && sb.accepted >= HoldAfter) begin
      held      = 1'b1;
      hold_left = HoldCycles - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_left > 0) begin
      rx_left--;
      out_stall <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode_left = $urandom_range(20, 100);
        rx_pct       = ($urandom_range(0, 2) == 0) ? 0 : 30;
      end else begin
        rx_mode_left--;
      end
      if ($urandom_range(0, 99) < rx_pct) begin
        rx_left = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("calendar_date_add_days verification failed");
    $finish;
  end

  function automatic in_t mk_date(int unsigned d, int unsigned m, int unsigned y);
    in_t r;
    r.start_day   = d[DayW-1:0];
    r.start_month = m[MonW-1:0];
    r.start_year  = y[YearW-1:0];
    return r;
  endfunction

  // mostly real dates, leaning on leap rules and month ends; some broken or raw noise
  function automatic in_t random_date();
    int unsigned y;
    int unsigned m;
    int unsigned len;
    int unsigned kind;
    case ($urandom_range(0, 9))
      0, 1, 2: y = $urandom_range(1, 9999);
      3:       y = 400 * $urandom_range(1, 40);
      4:       y = 100 * $urandom_range(1, 163);
      5, 6:    y = 4 * $urandom_range(1, 4095);
      7:       y = $urandom_range(1, 30);
      default: y = $urandom_range(9990, 16383);
    endcase
    kind = $urandom_range(0, 19);
    if (kind < 2)
      return mk_date($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383));
    m   = $urandom_range(1, 12);
    len = date_board::month_days(m, y);
    case (kind)
      2:       return mk_date(len + 1, m, y);
      3:       return mk_date($urandom_range(0, 31), m, y);
      4:       return mk_date($urandom_range(1, 28), $urandom_range(13, 15), y);
      5:       return mk_date($urandom_range(1, 28), 0, y);
      6:       return mk_date(29, MON_FEB, y);
      7, 8, 9: return mk_date(len, m, y);
      10, 11:  return mk_date(1, m, y);
      default: return mk_date($urandom_range(1, len), m, y);
    endcase
  endfunction

  // offer one date and hold it until taken
  task automatic send_date(in_t d);
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid and wait for every expected result, then let the core settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // offset register write while the block is idle
  task automatic write_offset(logic [OffW-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.offset = v;
  endtask

  // random dates with sender gaps in bursts
  task automatic random_dates(int unsigned n, bit last_phase);
    int unsigned i;
    int unsigned mode_left;
    int unsigned gap_pct;
    mode_left = 0;
    gap_pct   = 0;
    for (i = 0; i < n; i++) begin
      if (last_phase && i >= n - CalmItems) calm = 1'b1;
      send_date(random_date());
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 80);
        gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : 30;
      end else begin
        mode_left--;
      end
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
  endtask

  // stimulus
  initial begin
    in_t             directed_q[$];
    logic [OffW-1:0] offsets[NumPhases];
    int unsigned     p;
    sb           = new();
    calm         = 1'b0;
    held         = 1'b0;
    hold_left    = 0;
    rx_left      = 0;
    rx_mode_left = 0;
    rx_pct       = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed dates under the reset offset
    directed_q = '{
      mk_date(1, 1, 1),       mk_date(31, 12, 9999),  mk_date(0, 1, 2000),
      mk_date(31, 0, 2000),   mk_date(1, 13, 2000),   mk_date(1, 15, 2000),
      mk_date(1, 1, 0),       mk_date(1, 1, 16383),   mk_date(29, 2, 2000),
      mk_date(29, 2, 1900),   mk_date(29, 2, 2024),   mk_date(29, 2, 2023),
      mk_date(31, 4, 2023),   mk_date(30, 4, 2023),   mk_date(31, 1, 2024),
      mk_date(31, 1, 2023),   mk_date(1, 11, 2023),   mk_date(2, 11, 2023),
      mk_date(1, 11, 2024),   mk_date(2, 11, 2024),   mk_date(31, 15, 16383),
      mk_date(0, 0, 0),       mk_date(16, 8, 8192),   mk_date(31, 10, 16000)
    };
    foreach (directed_q[i]) send_date(directed_q[i]);

    // offset settings, extremes included, back to the reset value at the end
    offsets[0] = '0;
    offsets[1] = '1;
    offsets[2] = 9'd1;
    offsets[3] = 9'd366;
    offsets[4] = 9'd365;
    offsets[5] = 9'($urandom_range(2, 364));
    offsets[6] = 9'd256;
    offsets[7] = OFFSET_RESET;
    for (p = 0; p < NumPhases; p++) begin
      write_offset(offsets[p]);
      random_dates(PhaseItems, p == NumPhases - 1);
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("calendar_date_add_days verification clean");
    end else begin
      $display("calendar_date_add_days verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cda_pkg.sv
rtl/cda_leap.sv
rtl/cda_walk.sv
rtl/calendar_date_add_days.sv
test/tb_calendar_date_add_days.sv
